// ----- src/tsyn_pkg.sv -----
// Package for the TCP SYN header extractor: word types, header offsets and
// protocol codes. No dependencies; used by tcp_syn_header_extractor_unit.
package tsyn_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;

  // Fixed byte offsets inside the frame
  localparam logic [15:0] OFS_ETYPE_HI  = 16'd12;
  localparam logic [15:0] OFS_ETYPE_LO  = 16'd13;
  localparam logic [15:0] OFS_IHL       = 16'd14;
  localparam logic [15:0] OFS_PROTO     = 16'd23;
  localparam logic [15:0] OFS_SRC_FIRST = 16'd26;
  localparam logic [15:0] OFS_SRC_LAST  = 16'd29;
  localparam logic [15:0] OFS_DST_FIRST = 16'd30;
  localparam logic [15:0] OFS_DST_LAST  = 16'd33;

  // Minimum frame lengths for each header
  localparam logic [15:0] MIN_ETH_LEN = 16'd14;
  localparam logic [15:0] MIN_IP_LEN  = 16'd34;
  localparam logic [6:0]  TCP_HDR_LEN = 7'd20;
  localparam logic [6:0]  TCP_FLAG_OFS = 7'd13;
  localparam int unsigned TCP_SYN_BIT = 1;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } tsyn_in_t;

  typedef struct packed {
    logic        verdict;
    logic        syn_event;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] frame_length;
  } tsyn_out_t;

endpackage

// ----- src/tcp_syn_header_extractor_unit.sv -----
// TCP SYN header extractor, top level.
// Depends on tsyn_pkg for word types, offsets and protocol codes.
//
// Usage: frame bytes enter on the byte channel (byte_valid/byte_ready,
// byte_data), one word per byte in wire order, is_last set on the final byte.
// A byte counter picks out EtherType, IHL, IP protocol, IPv4 addresses, TCP
// ports and the TCP flag byte. Only the final byte of a frame produces a word
// on the result channel (result_valid/result_ready, result_data): verdict 1
// for a truncated header, else a pass with syn_event set for a TCP SYN, the
// addresses and ports (zero without an event) and the saturated length.
// Throughput: one byte per cycle, set by the single result register, except
// while a result waits; the header checks are a few offset compares on the
// byte counter. The result word is valid in the cycle after the final byte is
// accepted. When the receiver stalls, the result register holds and
// byte_ready drops only while a result waits and result_ready is low.
// Reset (rst, synchronous): counter and captured fields clear, no result is
// pending. After each final byte the capture state clears for the next frame.
module tcp_syn_header_extractor_unit
  import tsyn_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  tsyn_in_t  byte_data,
  output logic      result_valid,
  input  logic      result_ready,
  output tsyn_out_t result_data
);

  localparam logic [15:0] LEN_CAP = 16'(MAX_FRAME_BYTES);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] ether_kind, ether_kind_next;
  logic [7:0]  ip_protocol_seen, ip_protocol_seen_next;
  logic [3:0]  header_words, header_words_next;
  logic [31:0] captured_source, captured_source_next;
  logic [31:0] captured_destination, captured_destination_next;
  logic [15:0] captured_source_port, captured_source_port_next;
  logic [15:0] captured_destination_port, captured_destination_port_next;
  logic [7:0]  tcp_flag_byte, tcp_flag_byte_next;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] pos;
  logic [6:0]  tcp_start;
  logic [15:0] tcp_start_w;
  logic [15:0] count;
  tsyn_out_t   result_next;

  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_data.frame_byte;
  assign pos        = byte_position;

  // Field capture: the IHL nibble takes effect on its own byte
  always_comb begin
    ether_kind_next                = ether_kind;
    ip_protocol_seen_next          = ip_protocol_seen;
    header_words_next              = header_words;
    captured_source_next           = captured_source;
    captured_destination_next      = captured_destination;
    captured_source_port_next      = captured_source_port;
    captured_destination_port_next = captured_destination_port;
    tcp_flag_byte_next             = tcp_flag_byte;

    if (pos == OFS_ETYPE_HI || pos == OFS_ETYPE_LO) begin
      ether_kind_next = {ether_kind[7:0], b};
    end
    if (pos == OFS_IHL) begin
      header_words_next = b[3:0];
    end
    if (pos == OFS_PROTO) begin
      ip_protocol_seen_next = b;
    end
    if (pos >= OFS_SRC_FIRST && pos <= OFS_SRC_LAST) begin
      captured_source_next = {captured_source[23:0], b};
    end
    if (pos >= OFS_DST_FIRST && pos <= OFS_DST_LAST) begin
      captured_destination_next = {captured_destination[23:0], b};
    end

    tcp_start   = 7'(OFS_IHL) + {1'b0, header_words_next, 2'b00};
    tcp_start_w = {9'd0, tcp_start};

    if (pos == tcp_start_w || pos == tcp_start_w + 16'd1) begin
      captured_source_port_next = {captured_source_port[7:0], b};
    end
    if (pos == tcp_start_w + 16'd2 || pos == tcp_start_w + 16'd3) begin
      captured_destination_port_next = {captured_destination_port[7:0], b};
    end
    if (pos == tcp_start_w + {9'd0, TCP_FLAG_OFS}) begin
      tcp_flag_byte_next = b;
    end

    count = (pos != POS_MAX) ? pos + 16'd1 : POS_MAX;
  end

  // Header checks on the final byte, in priority order
  always_comb begin
    result_next = '0;
    if (count < MIN_ETH_LEN) begin
      result_next.verdict = 1'b1;
    end else if (ether_kind_next != ETHERTYPE_IPV4) begin
      result_next.verdict = 1'b0;
    end else if (count < MIN_IP_LEN) begin
      result_next.verdict = 1'b1;
    end else if (ip_protocol_seen_next != PROTO_TCP) begin
      result_next.verdict = 1'b0;
    end else if (count < tcp_start_w + {9'd0, TCP_HDR_LEN}) begin
      result_next.verdict = 1'b1;
    end else if (tcp_flag_byte_next[TCP_SYN_BIT]) begin
      result_next.syn_event           = 1'b1;
      result_next.source_address      = captured_source_next;
      result_next.destination_address = captured_destination_next;
      result_next.source_port         = captured_source_port_next;
      result_next.destination_port    = captured_destination_port_next;
    end
    result_next.frame_length = (count < LEN_CAP) ? count : LEN_CAP;
  end

  assign byte_position_next = byte_data.is_last ? 16'd0 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position             <= '0;
      ether_kind                <= '0;
      ip_protocol_seen          <= '0;
      header_words              <= '0;
      captured_source           <= '0;
      captured_destination      <= '0;
      captured_source_port      <= '0;
      captured_destination_port <= '0;
      tcp_flag_byte             <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      if (byte_data.is_last) begin
        // clear capture state for the next frame
        ether_kind                <= '0;
        ip_protocol_seen          <= '0;
        header_words              <= '0;
        captured_source           <= '0;
        captured_destination      <= '0;
        captured_source_port      <= '0;
        captured_destination_port <= '0;
        tcp_flag_byte             <= '0;
      end else begin
        ether_kind                <= ether_kind_next;
        ip_protocol_seen          <= ip_protocol_seen_next;
        header_words              <= header_words_next;
        captured_source           <= captured_source_next;
        captured_destination      <= captured_destination_next;
        captured_source_port      <= captured_source_port_next;
        captured_destination_port <= captured_destination_port_next;
        tcp_flag_byte             <= tcp_flag_byte_next;
      end
    end
  end

  // Result register: load on a final byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && byte_data.is_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_data.is_last) begin
      result_data <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && byte_data.is_last |=> byte_position == 16'd0 && header_words == 4'd0)
    else $error("capture state not cleared after final byte");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !byte_data.is_last && byte_position != POS_MAX
    |=> byte_position == $past(byte_position) + 16'd1)
    else $error("byte counter did not advance");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && byte_data.is_last |=> result_valid)
    else $error("final byte produced no result");

  a_syn_not_abort: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.syn_event |-> !result_data.verdict)
    else $error("SYN event reported with abort verdict");

  a_no_event_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.syn_event
    |-> result_data.source_address == 32'd0 && result_data.destination_address == 32'd0
        && result_data.source_port == 16'd0 && result_data.destination_port == 16'd0)
    else $error("address or port fields set without SYN event");
`endif

endmodule

// ----- test/tsyn_checker.sv -----
// Checker for the TCP SYN header extractor: watches both channels, predicts the
// per-frame summary word and compares it field by field with the block's output.
// Depends on tsyn_pkg for word types, header offsets and protocol codes.
module tsyn_checker
  import tsyn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic      byte_ready,
  input  tsyn_in_t  byte_data,
  input  logic      result_valid,
  input  logic      result_ready,
  input  tsyn_out_t result_data,
  output int        fail_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] bytes_seen;
  logic [15:0] ether_acc;
  logic [7:0]  proto_acc;
  logic [3:0]  ihl_acc;
  logic [31:0] src_addr_acc;
  logic [31:0] dst_addr_acc;
  logic [15:0] src_port_acc;
  logic [15:0] dst_port_acc;
  logic [7:0]  tcp_flags_acc;

  tsyn_out_t expected_summaries[$];
  int mismatches = 0;
  int waiting = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  task automatic clear_frame_state();
    bytes_seen    = '0;
    ether_acc     = '0;
    proto_acc     = '0;
    ihl_acc       = '0;
    src_addr_acc  = '0;
    dst_addr_acc  = '0;
    src_port_acc  = '0;
    dst_port_acc  = '0;
    tcp_flags_acc = '0;
  endtask

  // Fold one frame byte into the capture state; on the last byte queue the summary.
  task automatic absorb_frame_byte(input tsyn_in_t w);
    int unsigned at;
    int unsigned tcp_at;
    int unsigned count;
    tsyn_out_t summary;
    at = bytes_seen;
    if (at == OFS_ETYPE_HI || at == OFS_ETYPE_LO) ether_acc = {ether_acc[7:0], w.frame_byte};
    if (at == OFS_IHL) ihl_acc = w.frame_byte[3:0];
    if (at == OFS_PROTO) proto_acc = w.frame_byte;
    if (at >= OFS_SRC_FIRST && at <= OFS_SRC_LAST)
      src_addr_acc = {src_addr_acc[23:0], w.frame_byte};
    if (at >= OFS_DST_FIRST && at <= OFS_DST_LAST)
      dst_addr_acc = {dst_addr_acc[23:0], w.frame_byte};
    // TCP start uses the word count as it stands after this byte
    tcp_at = 14 + 4 * ihl_acc;
    if (at == tcp_at || at == tcp_at + 1) src_port_acc = {src_port_acc[7:0], w.frame_byte};
    if (at == tcp_at + 2 || at == tcp_at + 3)
      dst_port_acc = {dst_port_acc[7:0], w.frame_byte};
    if (at == tcp_at + TCP_FLAG_OFS) tcp_flags_acc = w.frame_byte;
    count = (at < POS_MAX) ? at + 1 : POS_MAX;
    bytes_seen = count[15:0];
    if (w.is_last) begin
      summary = '0;
      if (count < MIN_ETH_LEN) begin
        summary.verdict = 1'b1;
      end else if (ether_acc != ETHERTYPE_IPV4) begin
        summary.verdict = 1'b0;
      end else if (count < MIN_IP_LEN) begin
        summary.verdict = 1'b1;
      end else if (proto_acc != PROTO_TCP) begin
        summary.verdict = 1'b0;
      end else if (count < tcp_at + TCP_HDR_LEN) begin
        summary.verdict = 1'b1;
      end else if (tcp_flags_acc[TCP_SYN_BIT]) begin
        summary.syn_event           = 1'b1;
        summary.source_address      = src_addr_acc;
        summary.destination_address = dst_addr_acc;
        summary.source_port         = src_port_acc;
        summary.destination_port    = dst_port_acc;
      end
      summary.frame_length = 16'((count < MAX_FRAME_BYTES_DEF) ? count : MAX_FRAME_BYTES_DEF);
      expected_summaries.push_back(summary);
      clear_frame_state();
    end
  endtask

  task automatic compare_summary(input tsyn_out_t got);
    tsyn_out_t want;
    if (expected_summaries.size() == 0) begin
      $error("result word with no frame pending");
      mismatches++;
    end else begin
      want = expected_summaries.pop_front();
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
        mismatches++;
      end
      if (got.syn_event !== want.syn_event) begin
        $error("syn_event: expected %0d, got %0d", want.syn_event, got.syn_event);
        mismatches++;
      end
      if (got.source_address !== want.source_address) begin
        $error("source_address: expected %h, got %h", want.source_address, got.source_address);
        mismatches++;
      end
      if (got.destination_address !== want.destination_address) begin
        $error("destination_address: expected %h, got %h",
               want.destination_address, got.destination_address);
        mismatches++;
      end
      if (got.source_port !== want.source_port) begin
        $error("source_port: expected %h, got %h", want.source_port, got.source_port);
        mismatches++;
      end
      if (got.destination_port !== want.destination_port) begin
        $error("destination_port: expected %h, got %h",
               want.destination_port, got.destination_port);
        mismatches++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame_state();
      expected_summaries.delete();
    end else begin
      // retire the output word first: it always belongs to an earlier frame
      if (result_valid && result_ready) compare_summary(result_data);
      if (byte_valid && byte_ready) absorb_frame_byte(byte_data);
    end
    waiting = expected_summaries.size();
  end

endmodule

// ----- test/tcp_syn_header_extractor_unit_tb.sv -----
// Testbench top for the TCP SYN header extractor: clock, reset, frame stimulus
// with random idling on both channels, and the final verdict.
// Depends on tsyn_pkg, tcp_syn_header_extractor_unit and tsyn_checker.
module tcp_syn_header_extractor_unit_tb;
  import tsyn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_ready;
  tsyn_in_t  byte_data;
  logic      result_valid;
  logic      result_ready;
  tsyn_out_t result_data;
  int        fail_count;
  int        outstanding;

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int cycle_count;
  logic [7:0] frame_bytes[$];

  tcp_syn_header_extractor_unit uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  tsyn_checker frame_watch (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: stall at random per cycle
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic put_byte(input logic [7:0] value, input logic last);
    // idle each cycle with the sender's idle odds
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{frame_byte: value, is_last: last};
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Build a frame with the header fields placed where they fit, then send it.
  task automatic emit_frame(input fill_kind_t fill, input logic [15:0] etype,
                            input logic [3:0] ihl, input logic [7:0] proto,
                            input logic [7:0] flags, input int len);
    int tstart;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes.push_back(8'h00);
        FILL_ONES: frame_bytes.push_back(8'hFF);
        default:   frame_bytes.push_back(8'($urandom));
      endcase
    end
    tstart = 14 + 4 * ihl;
    if (len > 12) frame_bytes[12] = etype[15:8];
    if (len > 13) frame_bytes[13] = etype[7:0];
    if (len > 14) frame_bytes[14][3:0] = ihl;
    if (len > 23) frame_bytes[23] = proto;
    if (len > tstart + 13) frame_bytes[tstart + 13] = flags;
    foreach (frame_bytes[i]) put_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Mostly well-formed TCP frames; the rest truncated, other protocols or noise.
  task automatic random_frame();
    int pick;
    int ihl;
    int tstart;
    int len;
    logic [15:0] etype;
    logic [7:0] proto;
    pick   = $urandom_range(99);
    ihl    = ($urandom_range(99) < 80) ? 5 : $urandom_range(15);
    tstart = 14 + 4 * ihl;
    etype  = ETHERTYPE_IPV4;
    proto  = PROTO_TCP;
    len    = tstart + 20 + $urandom_range(10);
    if (pick >= 95) begin
      etype = 16'($urandom);
      proto = 8'($urandom);
      len   = $urandom_range(1, 80);
    end else if (pick >= 88) begin
      proto = 8'($urandom);
    end else if (pick >= 80) begin
      etype = 16'($urandom);
    end else if (pick >= 70) begin
      len = $urandom_range(1, tstart + 19);
    end
    emit_frame(FILL_RANDOM, etype, ihl[3:0], proto, 8'($urandom), len);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int start_bytes;
    int frames;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_bytes = bytes_sent;
    frames = 0;
    while (bytes_sent - start_bytes < 330 || frames < 6) begin
      random_frame();
      frames++;
    end
  endtask

  initial begin
    rst           = 1'b1;
    byte_valid    = 1'b0;
    byte_data     = '0;
    send_idle_pct = 11;
    recv_idle_pct = 73;
    bytes_sent    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // truncated Ethernet header, single byte and one short of it
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h02, 1);
    emit_frame(FILL_ONES, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h02, 13);
    // IPv4 header cut short, and a non-IPv4 frame of the same size
    emit_frame(FILL_ZERO, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h02, 14);
    emit_frame(FILL_ONES, 16'h86DD, 4'd5, PROTO_TCP, 8'h02, 14);
    // TCP header cut short, and non-TCP protocol
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h02, 34);
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd5, 8'h11, 8'h02, 54);
    // SYN with all-ones and all-zero fields, one byte short, SYN bit clear
    emit_frame(FILL_ONES, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'hFF, 54);
    emit_frame(FILL_ZERO, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h02, 54);
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h02, 53);
    emit_frame(FILL_ONES, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'hFD, 54);
    // header word counts below five overlap TCP with IP; fifteen is the longest
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, 8'h02, 34);
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd3, PROTO_TCP, 8'h02, 46);
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 8'h02, 94);
    emit_frame(FILL_RANDOM, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 8'h02, 93);

    run_phase(11, 73);
    run_phase(73, 11);
    run_phase(0, 0);
    byte_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
